// ===== rtl/core/pli_pkg.sv =====
// shared types and constants for the piecewise linear table interpolator
`default_nettype none
package pli_pkg;

  localparam int TableEntries = 128;
  localparam int IdxBits      = $clog2(TableEntries);
  localparam int CountBits    = 8;
  localparam int KeyBits      = 36;
  localparam int ValueBits    = 32;
  localparam int StepBits     = $clog2(ValueBits);

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  localparam logic [1:0] RelInterp = 2'd0;
  localparam logic [1:0] RelBelow  = 2'd1;
  localparam logic [1:0] RelAbove  = 2'd2;
  localparam logic [1:0] RelNone   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_SCAN,
    ST_ARITH
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_e;

endpackage
`default_nettype wire

// ===== rtl/core/pli_muldiv.sv =====
// shift-add multiply then restoring divide on one shared adder
`default_nettype none
module pli_muldiv (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           go_i,
  input  wire logic [pli_pkg::KeyBits-1:0]    off_i,
  input  wire logic [pli_pkg::KeyBits-1:0]    span_i,
  input  wire logic [pli_pkg::ValueBits-1:0]  mult_i,
  output logic                                done_o,
  output logic [pli_pkg::ValueBits-1:0]       quo_o,
  output logic                                inexact_o
);

  localparam int KB = pli_pkg::KeyBits;
  localparam int VB = pli_pkg::ValueBits;
  localparam int SB = pli_pkg::StepBits;

  pli_pkg::md_phase_e phase_q, phase_d;
  logic [SB-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [KB-1:0] acc_q, acc_d;
  logic [VB-1:0] lo_q, lo_d;
  logic [KB-1:0] off_q, off_d;
  logic [KB-1:0] span_q, span_d;

  logic [KB:0]   add_a;
  logic [KB:0]   add_b;
  logic          add_cin;
  logic [KB+1:0] sum;
  logic          geq;

  // shared adder
  always_comb begin
    if (phase_q == pli_pkg::MD_DIV) begin
      add_a   = {acc_q, lo_q[VB-1]};
      add_b   = ~{1'b0, span_q};
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, acc_q};
      add_b   = lo_q[0] ? {1'b0, off_q} : '0;
      add_cin = 1'b0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{(KB+1){1'b0}}, add_cin};
    geq = sum[KB+1];
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    lo_d    = lo_q;
    off_d   = off_q;
    span_d  = span_q;
    case (phase_q)
      pli_pkg::MD_IDLE: begin
        if (go_i) begin
          off_d   = off_i;
          span_d  = span_i;
          acc_d   = '0;
          lo_d    = mult_i;
          cnt_d   = '1;
          phase_d = pli_pkg::MD_MUL;
        end
      end
      pli_pkg::MD_MUL: begin
        acc_d = sum[KB:1];
        lo_d  = {sum[0], lo_q[VB-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          phase_d = pli_pkg::MD_DIV;
        end
      end
      pli_pkg::MD_DIV: begin
        acc_d = geq ? sum[KB-1:0] : add_a[KB-1:0];
        lo_d  = {lo_q[VB-2:0], geq};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          phase_d = pli_pkg::MD_IDLE;
          done_d  = 1'b1;
        end
      end
      default: phase_d = pli_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pli_pkg::MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    lo_q   <= lo_d;
    off_q  <= off_d;
    span_q <= span_d;
  end

  assign done_o    = done_q;
  assign quo_o     = lo_q;
  assign inexact_o = (acc_q != '0);

  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |-> phase_q == pli_pkg::MD_IDLE)
    else $error("muldiv started while running");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pli_pkg::MD_DIV |-> acc_q < span_q)
    else $error("partial remainder not below divisor");

  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(phase_q) == pli_pkg::MD_DIV && phase_q == pli_pkg::MD_IDLE)
    else $error("done without finishing divide");

endmodule
`default_nettype wire

// ===== rtl/core/piecewise_linear_table_interpolator_top.sv =====
// top level: breakpoint table, segment scan and result register
// A load item (kind 0) writes one breakpoint. A query item scans the table linearly from slot 0,
// one slot per cycle through the table memory read port; if the key falls inside a segment of
// nonzero width, it runs a 32-step shift-add multiply and a 32-step restoring divide on one
// shared adder. With fewer than two entries a query returns without a scan; otherwise busy stays
// high until the result. The result appears on the result ports for one cycle with
// result_valid_o and cannot be held off by the receiver, and the next item may be started in that
// same cycle.
`default_nettype none
module piecewise_linear_table_interpolator_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                kind_i,
  input  wire logic [pli_pkg::IdxBits-1:0]         entry_index_i,
  input  wire logic [pli_pkg::KeyBits-1:0]         entry_key_i,
  input  wire logic [pli_pkg::ValueBits-1:0]       entry_value_i,
  input  wire logic [pli_pkg::KeyBits-1:0]         query_key_i,
  input  wire logic                                entry_count_we_i,
  input  wire logic [pli_pkg::CountBits-1:0]       entry_count_i,
  output logic                                     result_valid_o,
  output logic [pli_pkg::ValueBits-1:0]            estimated_value_o,
  output logic [1:0]                               relation_o
);

  localparam int KB = pli_pkg::KeyBits;
  localparam int VB = pli_pkg::ValueBits;
  localparam int CB = pli_pkg::CountBits;
  localparam int IB = pli_pkg::IdxBits;

  logic [KB-1:0] key_mem [pli_pkg::TableEntries];
  logic [VB-1:0] val_mem [pli_pkg::TableEntries];
  logic [KB-1:0] rd_key_q;
  logic [VB-1:0] rd_val_q;

  pli_pkg::state_e state_q, state_d;
  logic [CB-1:0] count_q;
  logic [CB-1:0] n_q, n_d;
  logic [CB-1:0] idx_q, idx_d;
  logic [KB-1:0] qk_q, qk_d;
  logic [KB-1:0] prev_key_q, prev_key_d;
  logic [VB-1:0] prev_val_q, prev_val_d;
  logic [KB-1:0] first_key_q, first_key_d;
  logic [VB-1:0] first_val_q, first_val_d;
  logic [VB-1:0] v0_q, v0_d;
  logic          rising_q, rising_d;
  logic          res_valid_q, res_valid_d;
  logic [VB-1:0] res_val_q, res_val_d;
  logic [1:0]    res_rel_q, res_rel_d;

  logic          accept;
  logic          wr_en;
  logic [CB-1:0] n_clamped;
  logic          md_go;
  logic [KB-1:0] md_off;
  logic [KB-1:0] md_span;
  logic [VB-1:0] md_mult;
  logic          md_done;
  logic [VB-1:0] md_quo;
  logic          md_inexact;
  logic          seg_hit;
  logic          seg_rising;

  assign busy      = (state_q != pli_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign wr_en     = accept && (kind_i == pli_pkg::KindLoad);
  assign n_clamped = (count_q > CB'(pli_pkg::TableEntries)) ? CB'(pli_pkg::TableEntries)
                                                            : count_q;

  // table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[entry_index_i] <= entry_key_i;
      val_mem[entry_index_i] <= entry_value_i;
    end
    rd_key_q <= key_mem[idx_q[IB-1:0]];
    rd_val_q <= val_mem[idx_q[IB-1:0]];
  end

  assign seg_hit    = (qk_q >= prev_key_q) && (qk_q <= rd_key_q);
  assign seg_rising = (rd_val_q >= prev_val_q);
  assign md_off     = qk_q - prev_key_q;
  assign md_span    = rd_key_q - prev_key_q;
  assign md_mult    = seg_rising ? (rd_val_q - prev_val_q) : (prev_val_q - rd_val_q);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    idx_d       = idx_q;
    qk_d        = qk_q;
    prev_key_d  = prev_key_q;
    prev_val_d  = prev_val_q;
    first_key_d = first_key_q;
    first_val_d = first_val_q;
    v0_d        = v0_q;
    rising_d    = rising_q;
    res_valid_d = 1'b0;
    res_val_d   = res_val_q;
    res_rel_d   = res_rel_q;
    md_go       = 1'b0;
    case (state_q)
      pli_pkg::ST_IDLE: begin
        if (accept && (kind_i == pli_pkg::KindQuery)) begin
          qk_d  = query_key_i;
          n_d   = n_clamped;
          idx_d = '0;
          if (n_clamped < CB'(2)) begin
            res_valid_d = 1'b1;
            res_val_d   = '0;
            res_rel_d   = pli_pkg::RelNone;
          end else begin
            state_d = pli_pkg::ST_LOAD0;
          end
        end
      end
      pli_pkg::ST_LOAD0: begin
        idx_d   = idx_q + 1'b1;
        state_d = pli_pkg::ST_SCAN;
      end
      pli_pkg::ST_SCAN: begin
        // rd holds slot idx_q - 1
        if (idx_q == CB'(1)) begin
          prev_key_d  = rd_key_q;
          prev_val_d  = rd_val_q;
          first_key_d = rd_key_q;
          first_val_d = rd_val_q;
          idx_d       = idx_q + 1'b1;
        end else if (seg_hit) begin
          if (md_span == '0) begin
            res_valid_d = 1'b1;
            res_val_d   = prev_val_q;
            res_rel_d   = pli_pkg::RelInterp;
            state_d     = pli_pkg::ST_IDLE;
          end else begin
            md_go    = 1'b1;
            v0_d     = prev_val_q;
            rising_d = seg_rising;
            state_d  = pli_pkg::ST_ARITH;
          end
        end else if (idx_q == n_q) begin
          res_valid_d = 1'b1;
          state_d     = pli_pkg::ST_IDLE;
          if (qk_q < first_key_q) begin
            res_val_d = first_val_q;
            res_rel_d = pli_pkg::RelBelow;
          end else begin
            res_val_d = rd_val_q;
            res_rel_d = pli_pkg::RelAbove;
          end
        end else begin
          prev_key_d = rd_key_q;
          prev_val_d = rd_val_q;
          idx_d      = idx_q + 1'b1;
        end
      end
      pli_pkg::ST_ARITH: begin
        if (md_done) begin
          res_valid_d = 1'b1;
          res_rel_d   = pli_pkg::RelInterp;
          res_val_d   = rising_q ? (v0_q + md_quo)
                                 : (v0_q - md_quo - {{(VB-1){1'b0}}, md_inexact});
          state_d     = pli_pkg::ST_IDLE;
        end
      end
      default: state_d = pli_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pli_pkg::ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      if (entry_count_we_i) begin
        count_q <= entry_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qk_q        <= qk_d;
    prev_key_q  <= prev_key_d;
    prev_val_q  <= prev_val_d;
    first_key_q <= first_key_d;
    first_val_q <= first_val_d;
    v0_q        <= v0_d;
    rising_q    <= rising_d;
    res_val_q   <= res_val_d;
    res_rel_q   <= res_rel_d;
  end

  pli_muldiv u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (md_go),
    .off_i     (md_off),
    .span_i    (md_span),
    .mult_i    (md_mult),
    .done_o    (md_done),
    .quo_o     (md_quo),
    .inexact_o (md_inexact)
  );

  assign result_valid_o    = res_valid_q;
  assign estimated_value_o = res_val_q;
  assign relation_o        = res_rel_q;

  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy) || ($past(start) && $past(kind_i) == pli_pkg::KindQuery))
    else $error("result without a query");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while busy");

  a_busy_has_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (n_q >= CB'(2)))
    else $error("scan with fewer than two entries");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (idx_q <= n_q))
    else $error("scan index past entry count");

endmodule
`default_nettype wire
